// File: src/lpd_pkg.sv
// shared types and constants of the length-prefixed deframer
`default_nettype none
package lpd_pkg;

   localparam int unsigned DATA_W    = 8;
   localparam int unsigned LEN_W     = 32;
   localparam int unsigned SHIFT_W   = 24;
   localparam int unsigned HCNT_W    = 3;
   localparam int unsigned CSR_ADR_W = 3;
   localparam int unsigned CSR_DAT_W = 32;

   localparam logic [HCNT_W-1:0] HDR_LAST_BYTE = HCNT_W'(3);
   localparam logic [HCNT_W-1:0] PAYLOAD_PHASE = HCNT_W'(4);

   localparam logic [LEN_W-1:0] LIMIT_RESET = LEN_W'(1048576);

   localparam logic REQ_BYTE  = 1'b0;
   localparam logic REQ_CLEAR = 1'b1;

   localparam logic [CSR_ADR_W-1:0] CSR_PAYLOAD_LIMIT = CSR_ADR_W'(0);

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_ZERO_LEN  = 2'd1,
      STATUS_OVER_LIMIT = 2'd2
   } status_type;

   typedef struct packed {
      logic              valid;
      logic              req_type;
      logic [DATA_W-1:0] data_byte;
   } item_type;

   typedef struct packed {
      logic [DATA_W-1:0] payload_byte;
      logic              byte_valid;
      logic              frame_last;
      status_type        status;
      logic              failed_flag;
      logic              partial_flag;
   } result_type;

endpackage
`default_nettype wire

// File: src/length_prefixed_deframer_core.sv
// top level of the length-prefixed deframer
// a request transaction is held in the input register, then in the result register, before its result is output
// throughput: one transaction per cycle while results are not stalled, limited by the single frame state update
// a stalled result holds the pipeline; an empty input register still takes a request while results wait
// reset (synchronous, active high) clears frame state and failure, limit back to 1048576
`default_nettype none
module length_prefixed_deframer_core
   import lpd_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic                 req_type,
   input  wire logic [DATA_W-1:0]    req_data_byte,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic      [DATA_W-1:0]    rsp_payload_byte,
   output logic                      rsp_byte_valid,
   output logic                      rsp_frame_last,
   output logic      [1:0]           rsp_status,
   output logic                      rsp_failed_flag,
   output logic                      rsp_partial_flag,
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire logic [CSR_ADR_W-1:0] paddr,
   input  wire logic [CSR_DAT_W-1:0] pwdata,
   output logic      [CSR_DAT_W-1:0] prdata,
   output logic                      pready
);

   logic             advance;
   logic [LEN_W-1:0] payload_limit;
   item_type         item;
   result_type       result;

   lpd_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .payload_limit (payload_limit)
   );

   lpd_input_stage u_input (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_type      (req_type),
      .req_data_byte (req_data_byte),
      .advance       (advance),
      .item          (item)
   );

   lpd_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .item          (item),
      .payload_limit (payload_limit),
      .advance       (advance),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .result        (result)
   );

   assign rsp_payload_byte = result.payload_byte;
   assign rsp_byte_valid   = result.byte_valid;
   assign rsp_frame_last   = result.frame_last;
   assign rsp_status       = result.status;
   assign rsp_failed_flag  = result.failed_flag;
   assign rsp_partial_flag = result.partial_flag;

endmodule
`default_nettype wire

// File: src/lpd_csr.sv
// configuration register block with apb-style access
`default_nettype none
module lpd_csr
   import lpd_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire logic [CSR_ADR_W-1:0] paddr,
   input  wire logic [CSR_DAT_W-1:0] pwdata,
   output logic      [CSR_DAT_W-1:0] prdata,
   output logic                      pready,
   output logic      [LEN_W-1:0]     payload_limit
);

   logic [LEN_W-1:0] limit_ff;
   logic [LEN_W-1:0] limit_in;
   logic             hit;

   assign hit = (paddr == CSR_PAYLOAD_LIMIT);

   always_comb begin
      limit_in = limit_ff;
      if (psel && penable && pwrite && hit) begin
         limit_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else begin
         limit_ff <= limit_in;
      end
   end

   assign prdata        = hit ? limit_ff : '0;
   assign pready        = 1'b1;
   assign payload_limit = limit_ff;

endmodule
`default_nettype wire

// File: src/lpd_input_stage.sv
// input register holding one request transaction
`default_nettype none
module lpd_input_stage
   import lpd_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_type,
   input  wire logic [DATA_W-1:0] req_data_byte,
   input  wire logic              advance,
   output item_type               item
);

   logic              valid_ff;
   logic              valid_in;
   logic              type_ff;
   logic [DATA_W-1:0] byte_ff;
   logic              load;

   assign load      = !valid_ff || advance;
   assign req_stall = !load;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && req_valid) begin
         type_ff <= req_type;
         byte_ff <= req_data_byte;
      end
   end

   assign item.valid     = valid_ff;
   assign item.req_type  = type_ff;
   assign item.data_byte = byte_ff;

endmodule
`default_nettype wire

// File: src/lpd_engine.sv
// frame state, length check and result register
`default_nettype none
module lpd_engine
   import lpd_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire item_type         item,
   input  wire logic [LEN_W-1:0] payload_limit,
   output logic                  advance,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output result_type            result
);

   logic [SHIFT_W-1:0] shift_ff,  shift_in;
   logic [HCNT_W-1:0]  hcount_ff, hcount_in;
   logic [LEN_W-1:0]   remain_ff, remain_in;
   logic               failed_ff, failed_in;
   status_type         code_ff,   code_in;
   logic               out_valid_ff, out_valid_in;
   result_type         result_ff, result_in;
   logic [LEN_W-1:0]   length;
   logic               fire;

   assign advance = !out_valid_ff || !rsp_stall;
   assign fire    = item.valid && advance;
   assign length  = {shift_ff, item.data_byte};

   always_comb begin
      shift_in  = shift_ff;
      hcount_in = hcount_ff;
      remain_in = remain_ff;
      failed_in = failed_ff;
      code_in   = code_ff;
      result_in = '0;
      if (item.req_type == REQ_CLEAR) begin
         shift_in  = '0;
         hcount_in = '0;
         remain_in = '0;
         failed_in = 1'b0;
         code_in   = STATUS_OK;
      end else if (failed_ff) begin
         // byte dropped
      end else if (hcount_ff < HDR_LAST_BYTE) begin
         shift_in  = {shift_ff[SHIFT_W-DATA_W-1:0], item.data_byte};
         hcount_in = hcount_ff + HCNT_W'(1);
      end else if (hcount_ff == HDR_LAST_BYTE) begin
         shift_in  = '0;
         if (length == '0) begin
            hcount_in = '0;
            failed_in = 1'b1;
            code_in   = STATUS_ZERO_LEN;
         end else if (length > payload_limit) begin
            hcount_in = '0;
            failed_in = 1'b1;
            code_in   = STATUS_OVER_LIMIT;
         end else begin
            hcount_in = PAYLOAD_PHASE;
            remain_in = length;
         end
      end else begin
         result_in.payload_byte = item.data_byte;
         result_in.byte_valid   = 1'b1;
         remain_in              = remain_ff - LEN_W'(1);
         if (remain_ff == LEN_W'(1)) begin
            result_in.frame_last = 1'b1;
            hcount_in            = '0;
         end
      end
      result_in.status       = failed_in ? code_in : STATUS_OK;
      result_in.failed_flag  = failed_in;
      result_in.partial_flag = (hcount_in != '0) || (remain_in != '0);
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = item.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff     <= '0;
         hcount_ff    <= '0;
         remain_ff    <= '0;
         failed_ff    <= 1'b0;
         code_ff      <= STATUS_OK;
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (fire) begin
            shift_ff  <= shift_in;
            hcount_ff <= hcount_in;
            remain_ff <= remain_in;
            failed_ff <= failed_in;
            code_ff   <= code_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign result    = result_ff;

   a_fail_clears_frame: assert property (@(posedge clock) disable iff (reset)
      failed_ff |-> (hcount_ff == '0) && (remain_ff == '0))
      else $error("frame state left behind a failure");

   a_fail_code_match: assert property (@(posedge clock) disable iff (reset)
      failed_ff == (code_ff != STATUS_OK))
      else $error("failure flag and code disagree");

   a_payload_has_count: assert property (@(posedge clock) disable iff (reset)
      (hcount_ff == PAYLOAD_PHASE) |-> (remain_ff != '0))
      else $error("payload phase with nothing left to receive");

   a_last_is_data: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && result_ff.frame_last) |->
         (result_ff.byte_valid && !result_ff.partial_flag))
      else $error("frame end flagged without a payload byte");

   a_data_not_failed: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && result_ff.byte_valid) |->
         (!result_ff.failed_flag && result_ff.status == STATUS_OK))
      else $error("payload byte passed out while failed");

endmodule
`default_nettype wire
